// ===== rtl/irc_pkg.sv =====
package irc_pkg;

  // sizes
  localparam int MAX_TAPS    = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + ADDR_W;

  // reset value of the tap count register
  localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = COUNT_W'(MAX_TAPS);

  // half an output lsb, added before the shift
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  // item operations
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // control from the sequencer to the mac pipeline
  typedef struct packed {
    logic clear;
    logic issue;
    logic hist_zero;
  } mac_ctl_t;

endpackage

// ===== rtl/irc_ram.sv =====
module irc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/irc_mac.sv =====
module irc_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  irc_pkg::mac_ctl_t                       ctl,
  input  logic signed [irc_pkg::SAMPLE_BITS-1:0]  coef,
  input  logic signed [irc_pkg::SAMPLE_BITS-1:0]  hist,
  output logic                                    busy,
  output logic signed [irc_pkg::SAMPLE_BITS-1:0]  result
);
  import irc_pkg::*;

  localparam int SHIFT_W = ACC_W - FRAC_BITS;

  logic                       s1_valid;
  logic                       s1_zero;
  logic                       s2_valid;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [SHIFT_W-1:0]  shifted;

  // stage valids track the memory read and the product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
    end
  end

  // multiply, taps beyond the history fill count read as zero
  always_ff @(posedge clk) begin
    s1_zero <= ctl.hist_zero;
    if (s1_zero) begin
      prod <= '0;
    end else begin
      prod <= coef * hist;
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = s1_valid | s2_valid;

  // round half up, drop fraction, saturate
  always_comb begin
    rounded = acc + ROUND_HALF;
    shifted = rounded[ACC_W-1:FRAC_BITS];
    if (!shifted[SHIFT_W-1] && (|shifted[SHIFT_W-2:SAMPLE_BITS-1])) begin
      result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (shifted[SHIFT_W-1] && !(&shifted[SHIFT_W-2:SAMPLE_BITS-1])) begin
      result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/impulse_response_convolver.sv =====
// Direct-form FIR filter over a loaded impulse response, Q1.23 data.
// Input channel (in_valid/in_ready) carries one item: op selects a sample,
// a coefficient write (tap_index, tap_value) or a history clear.
// Output channel (out_valid/out_ready) carries out_sample, one per sample.
// Coefficient writes, history clears and unused ops complete in the
// accept cycle and give no result.
// A sample walks the taps through the coefficient and history memories,
// one read per cycle on each memory's single read port, followed by a
// two-stage multiply and accumulate. It walks n = min(tap_count, 1024)
// taps; the result shows once the last product is accumulated (no pipeline
// pass when n is zero) and in_ready returns at the same point, so no new
// item is accepted during a sample. tap_count is written through
// cfg_we/cfg_wdata while the block is idle, a user's rule the block does
// not enforce. Reset sets tap_count to 1024 and empties the history at
// once: a fill count marks the entries written since the last clear, so
// no clearing pass is run. Coefficients are undefined until written. A
// stalled receiver holds the result in the output register; the next item
// is still accepted, and its result waits until that register frees.
module impulse_response_convolver (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [irc_pkg::COUNT_W-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             op,
  input  logic signed [irc_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [irc_pkg::ADDR_W-1:0]             tap_index,
  input  logic signed [irc_pkg::SAMPLE_BITS-1:0] tap_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [irc_pkg::SAMPLE_BITS-1:0] out_sample
);
  import irc_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [COUNT_W-1:0]       tap_count;
  logic [COUNT_W-1:0]       taps;
  logic [COUNT_W-1:0]       taps_next;
  logic [COUNT_W-1:0]       taps_lim;
  logic [COUNT_W-1:0]       k;
  logic [COUNT_W-1:0]       k_next;
  logic [ADDR_W-1:0]        ptr;
  logic [ADDR_W-1:0]        ptr_next;
  logic [COUNT_W-1:0]       fill;
  logic [COUNT_W-1:0]       fill_next;
  logic                     accept;
  logic                     coef_we;
  logic                     hist_we;
  logic                     load_out;
  logic                     out_free;
  logic                     mac_busy;
  mac_ctl_t                 ctl;
  logic [SAMPLE_BITS-1:0]   coef_rd;
  logic [SAMPLE_BITS-1:0]   hist_rd;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  assign taps_lim = (tap_count > COUNT_W'(MAX_TAPS)) ? COUNT_W'(MAX_TAPS) : tap_count;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= '0;
      fill  <= '0;
      k     <= '0;
      taps  <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      fill  <= fill_next;
      k     <= k_next;
      taps  <= taps_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    fill_next  = fill;
    k_next     = k;
    taps_next  = taps;
    coef_we    = 1'b0;
    hist_we    = 1'b0;
    load_out   = 1'b0;
    ctl        = '0;
    ctl.hist_zero = (k >= fill);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_SAMPLE: begin
              hist_we   = 1'b1;
              ctl.clear = 1'b1;
              ptr_next  = ptr - 1'b1;
              fill_next = (fill == COUNT_W'(MAX_TAPS)) ? fill : fill + 1'b1;
              k_next    = '0;
              taps_next = taps_lim;
              state_next = (taps_lim == '0) ? ST_DRAIN : ST_RUN;
            end
            OP_COEF: begin
              coef_we = 1'b1;
            end
            OP_CLEAR: begin
              ptr_next  = '0;
              fill_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        ctl.issue = 1'b1;
        k_next    = k + 1'b1;
        if (k_next == taps) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= mac_result;
    end
  end

  // coefficient memory
  irc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_BITS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (tap_index),
    .wdata (tap_value),
    .raddr (k[ADDR_W-1:0]),
    .rdata (coef_rd)
  );

  // sample history memory, newest sample at ptr
  irc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_BITS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ptr - 1'b1),
    .wdata (in_sample),
    .raddr (ptr + k[ADDR_W-1:0]),
    .rdata (hist_rd)
  );

  // multiply-accumulate pipeline
  irc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .coef   ($signed(coef_rd)),
    .hist   ($signed(hist_rd)),
    .busy   (mac_busy),
    .result (mac_result)
  );

endmodule
